### design/turtle_plotter_grid_unit_assert.svh
// assertion macros for the turtle plotter grid unit
// included by the top level only; empty bodies when SYNTHESIS is defined
`ifndef TURTLE_PLOTTER_GRID_UNIT_ASSERT_SVH
`define TURTLE_PLOTTER_GRID_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication check
`define TPG_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpg: same-cycle check failed");
// next-cycle implication check
`define TPG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpg: next-cycle check failed");
`else
`define TPG_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define TPG_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### design/tpg_pkg.sv
// shared types, codes and widths of the turtle plotter grid unit
// no dependencies
`default_nettype none
package tpg_pkg;

   localparam int GRID_DEF    = 64;
   localparam int COORD_W     = 6;
   localparam int CNT_W       = COORD_W + 1;
   localparam int ROW_W       = 64;
   localparam int CSR_IDX_W   = 1;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 88;
   localparam int RSP_PAD_W   = 3;

   localparam logic [COORD_W-1:0] START_RESET = 6'd12;

   // commands
   localparam logic [2:0] CMD_PEN_UP   = 3'd0;
   localparam logic [2:0] CMD_PEN_DOWN = 3'd1;
   localparam logic [2:0] CMD_TURN_R   = 3'd2;
   localparam logic [2:0] CMD_TURN_L   = 3'd3;
   localparam logic [2:0] CMD_MOVE     = 3'd4;
   localparam logic [2:0] CMD_PRINT    = 3'd5;

   // headings
   localparam logic [1:0] HEAD_DOWN  = 2'd0;
   localparam logic [1:0] HEAD_RIGHT = 2'd1;
   localparam logic [1:0] HEAD_UP    = 2'd2;
   localparam logic [1:0] HEAD_LEFT  = 2'd3;
   localparam logic [1:0] TURN_R_INC = 2'd1;
   localparam logic [1:0] TURN_L_INC = 2'd3;

   // result kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_ROW    = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_X = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Y = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [COORD_W-1:0] row_index;
      logic [ROW_W-1:0]   row_bits;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [1:0]         heading;
      logic               pen_is_down;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic               rd_en;
      logic [COORD_W-1:0] rd_row;
      logic               wr_en;
      logic [COORD_W-1:0] wr_row;
   } mem_ctl_type;

   typedef struct packed {
      logic [1:0] occ;
      logic       can_push;
   } fifo_stat_type;

endpackage
`default_nettype wire

### design/tpg_grid_mem.sv
// grid row memory: one write and one registered read port per cycle
// per-row valid bits cleared by reset; depends on tpg_pkg
`default_nettype none
module tpg_grid_mem #(
   parameter int GRID = tpg_pkg::GRID_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tpg_pkg::mem_ctl_type ctl,
   input  wire logic [GRID-1:0]      wr_data,
   output logic [GRID-1:0]           rd_data
);
   localparam int AW = $clog2(GRID);

   logic [GRID-1:0] row_mem_ff [GRID];
   logic [GRID-1:0] rd_ff;
   logic [GRID-1:0] valid_ff;
   logic            rd_valid_ff;
   logic [AW-1:0]   rd_addr;
   logic [AW-1:0]   wr_addr;

   assign rd_addr = ctl.rd_row[AW-1:0];
   assign wr_addr = ctl.wr_row[AW-1:0];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         row_mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_ff <= row_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // a row never written reads as cleared
   assign rd_data = rd_valid_ff ? rd_ff : '0;

endmodule
`default_nettype wire

### design/tpg_rsp_fifo.sv
// two-entry result queue in front of the result channel
// depends on tpg_pkg
`default_nettype none
module tpg_rsp_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire tpg_pkg::rsp_type       push_data,
   input  wire logic                   take,
   output logic                        out_valid,
   output tpg_pkg::rsp_type            out_data,
   output tpg_pkg::fifo_stat_type      stat
);
   tpg_pkg::rsp_type entry_ff [2];
   logic       wp_ff;
   logic       wp_in;
   logic       rp_ff;
   logic       rp_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       pop;

   assign out_valid     = (cnt_ff != 2'd0);
   assign out_data      = entry_ff[rp_ff];
   assign pop           = out_valid & take;
   assign stat.occ      = cnt_ff;
   assign stat.can_push = (cnt_ff != 2'd2) | pop;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wp_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

### design/turtle_plotter_grid_unit.sv
// top level of the turtle plotter grid unit: command sequencer and channels
// depends on tpg_pkg, tpg_grid_mem, tpg_rsp_fifo and the assertion header
`default_nettype none
`include "turtle_plotter_grid_unit_assert.svh"

// Turtle graphics on a GRID x GRID bit grid kept in a row memory. One command
// word goes in at a time; req_tready is high only while the sequencer is idle.
// Pen up, turns and unused codes go from acceptance to the status word through
// accept, decode and respond. In pen down, the row under the pen is read,
// or-ed with the pen bit and written back. A pen-down move along a row is one
// read-modify-write of that row with a run mask; a pen-down move along a
// column walks the marked rows through the read and write ports of the row
// memory, reading one row while writing the previous one. Print streams GRID
// row words, one per cycle when the result side keeps up, paced by the one
// read port of the row memory. A two-entry result queue lets a new command
// start while earlier words are still waiting. Reset clears the grid through
// per-row valid bits; no clearing pass is needed.
module turtle_plotter_grid_unit #(
   parameter int GRID = tpg_pkg::GRID_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // command words
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata: command [2:0], steps [8:3], zero [15:9]
   input  wire logic [tpg_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // result words
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata: row_index, row_bits, pos_x, pos_y, heading, pen_is_down, zero pad
   output logic [tpg_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   // tuser: kind
   output logic                                   rsp_tuser,
   output logic                                   rsp_tlast,
   // start register writes
   input  wire logic                              csr_we,
   input  wire logic [tpg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tpg_pkg::COORD_W-1:0]       csr_wdata
);
   localparam int AW = $clog2(GRID);
   localparam int CW = tpg_pkg::COORD_W;
   localparam int NW = tpg_pkg::CNT_W;
   localparam logic [CW-1:0] MAX_C    = CW'(GRID - 1);
   localparam logic [NW-1:0] GRID_CNT = NW'(GRID);
   localparam logic [NW-1:0] ONE_CNT  = NW'(1);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_WALK   = 3'd2;
   localparam logic [2:0] S_PRINT  = 3'd3;
   localparam logic [2:0] S_RESP   = 3'd4;

   // saturate a coordinate at the far edge
   function automatic logic [CW-1:0] clamp_c(input logic [CW-1:0] v);
      return (v > MAX_C) ? MAX_C : v;
   endfunction

   logic [2:0]    state_ff,   state_in;
   logic [2:0]    cmd_ff;
   logic [CW-1:0] steps_ff;
   logic [CW-1:0] cur_x_ff,   cur_x_in;
   logic [CW-1:0] cur_y_ff,   cur_y_in;
   logic [1:0]    head_ff,    head_in;
   logic          pen_ff,     pen_in;
   logic [GRID-1:0] mask_ff,  mask_in;
   logic [CW-1:0] row_ff,     row_in;     // next row to read in a walk
   logic [CW-1:0] wrow_ff,    wrow_in;    // row being written back
   logic [NW-1:0] left_ff,    left_in;    // rows still to read in a walk
   logic          pend_ff,    pend_in;    // read data due for write back
   logic [NW-1:0] pi_ff,      pi_in;      // print rows issued
   logic [CW-1:0] po_ff,      po_in;      // print row being pushed
   logic          infl_ff,    infl_in;    // print read in flight

   // move geometry
   logic [NW-1:0] x_ext, y_ext, n_ext, max_ext;
   logic [NW-1:0] fwd_x, fwd_y, bwd_x, bwd_y, x_hi;
   logic [NW-1:0] avail, mark_cnt;
   logic [CW-1:0] mv_x, mv_y;
   logic          horiz;
   logic [GRID-1:0] run_mask;
   logic [GRID-1:0] pt_mask;

   // memory and queue hookup
   tpg_pkg::mem_ctl_type   mem_ctl;
   logic [GRID-1:0]        wr_data;
   logic [GRID-1:0]        rd_data;
   tpg_pkg::rsp_type       push_data;
   tpg_pkg::rsp_type       out_data;
   tpg_pkg::fifo_stat_type fifo_stat;
   logic                   fifo_push;
   logic                   pop;
   logic                   req_take;
   logic                   print_issue;
   logic [2:0]             print_load;

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid & req_tready;
   assign pop        = rsp_tvalid & rsp_tready;

   always_comb begin
      x_ext   = {1'b0, cur_x_ff};
      y_ext   = {1'b0, cur_y_ff};
      n_ext   = {1'b0, steps_ff};
      max_ext = {1'b0, MAX_C};
      fwd_x   = x_ext + n_ext;
      fwd_y   = y_ext + n_ext;
      bwd_x   = x_ext - n_ext;
      bwd_y   = y_ext - n_ext;
      mv_x    = cur_x_ff;
      mv_y    = cur_y_ff;
      horiz   = 1'b0;
      case (head_ff)
         tpg_pkg::HEAD_DOWN: begin
            avail = max_ext - y_ext + ONE_CNT;
            mv_y  = (fwd_y > max_ext) ? MAX_C : fwd_y[CW-1:0];
         end
         tpg_pkg::HEAD_RIGHT: begin
            avail = max_ext - x_ext + ONE_CNT;
            mv_x  = (fwd_x > max_ext) ? MAX_C : fwd_x[CW-1:0];
            horiz = 1'b1;
         end
         tpg_pkg::HEAD_UP: begin
            avail = y_ext + ONE_CNT;
            mv_y  = (n_ext > y_ext) ? '0 : bwd_y[CW-1:0];
         end
         default: begin
            avail = x_ext + ONE_CNT;
            mv_x  = (n_ext > x_ext) ? '0 : bwd_x[CW-1:0];
            horiz = 1'b1;
         end
      endcase
      // cells past the edge are dropped
      mark_cnt = (n_ext < avail) ? n_ext : avail;
      x_hi     = x_ext + mark_cnt;
   end

   // run of marked columns for a move along a row
   always_comb begin
      for (int j = 0; j < GRID; j++) begin
         if (head_ff == tpg_pkg::HEAD_RIGHT) begin
            run_mask[j] = (NW'(j) >= x_ext) && (NW'(j) < x_hi);
         end else begin
            run_mask[j] = (NW'(j) <= x_ext) && ((NW'(j) + mark_cnt) > x_ext);
         end
      end
   end

   always_comb begin
      pt_mask = '0;
      pt_mask[cur_x_ff[AW-1:0]] = 1'b1;
   end

   // print keeps at most two words queued or in flight
   assign print_load  = {1'b0, fifo_stat.occ} + {2'b0, infl_ff};
   assign print_issue = (pi_ff < GRID_CNT) && (print_load < (3'd2 + {2'b0, pop}));

   always_comb begin
      state_in  = state_ff;
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      head_in   = head_ff;
      pen_in    = pen_ff;
      mask_in   = mask_ff;
      row_in    = row_ff;
      wrow_in   = wrow_ff;
      left_in   = left_ff;
      pend_in   = 1'b0;
      pi_in     = pi_ff;
      po_in     = po_ff;
      infl_in   = 1'b0;
      mem_ctl   = '0;
      wr_data   = rd_data | mask_ff;
      fifo_push = 1'b0;
      push_data.kind        = tpg_pkg::KIND_STATUS;
      push_data.row_index   = '0;
      push_data.row_bits    = '0;
      push_data.pos_x       = cur_x_ff;
      push_data.pos_y       = cur_y_ff;
      push_data.heading     = head_ff;
      push_data.pen_is_down = pen_ff;
      push_data.last        = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESP;
            case (cmd_ff)
               tpg_pkg::CMD_PEN_UP: begin
                  pen_in = 1'b0;
               end
               tpg_pkg::CMD_PEN_DOWN: begin
                  pen_in   = 1'b1;
                  mask_in  = pt_mask;
                  row_in   = cur_y_ff;
                  left_in  = ONE_CNT;
                  state_in = S_WALK;
               end
               tpg_pkg::CMD_TURN_R: begin
                  head_in = head_ff + tpg_pkg::TURN_R_INC;
               end
               tpg_pkg::CMD_TURN_L: begin
                  head_in = head_ff + tpg_pkg::TURN_L_INC;
               end
               tpg_pkg::CMD_MOVE: begin
                  cur_x_in = mv_x;
                  cur_y_in = mv_y;
                  row_in   = cur_y_ff;
                  // a row move is one update, a column move one row per cell
                  mask_in  = horiz ? run_mask : pt_mask;
                  left_in  = horiz ? ONE_CNT : mark_cnt;
                  if (pen_ff && (mark_cnt != '0)) begin
                     state_in = S_WALK;
                  end
               end
               tpg_pkg::CMD_PRINT: begin
                  pi_in    = '0;
                  po_in    = '0;
                  state_in = S_PRINT;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_WALK: begin
            // read the next row while the previous one is written back
            if (left_ff != '0) begin
               mem_ctl.rd_en  = 1'b1;
               mem_ctl.rd_row = row_ff;
               row_in  = (head_ff == tpg_pkg::HEAD_UP) ? row_ff - CW'(1) : row_ff + CW'(1);
               wrow_in = row_ff;
               left_in = left_ff - ONE_CNT;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               mem_ctl.wr_en  = 1'b1;
               mem_ctl.wr_row = wrow_ff;
            end
            if (left_ff == '0) begin
               state_in = S_RESP;
            end
         end
         S_PRINT: begin
            if (print_issue) begin
               mem_ctl.rd_en  = 1'b1;
               mem_ctl.rd_row = pi_ff[CW-1:0];
               pi_in   = pi_ff + ONE_CNT;
               infl_in = 1'b1;
            end
            if (infl_ff) begin
               fifo_push           = 1'b1;
               push_data.kind      = tpg_pkg::KIND_ROW;
               push_data.row_index = po_ff;
               push_data.row_bits  = tpg_pkg::ROW_W'(rd_data);
               push_data.last      = (po_ff == MAX_C);
               po_in = po_ff + CW'(1);
               if (po_ff == MAX_C) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_RESP: begin
            if (fifo_stat.can_push) begin
               fifo_push = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a start write also places the pen
      if (csr_we) begin
         case (csr_index)
            tpg_pkg::CSR_START_X: cur_x_in = clamp_c(csr_wdata);
            tpg_pkg::CSR_START_Y: cur_y_in = clamp_c(csr_wdata);
            default: begin
               cur_x_in = cur_x_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cur_x_ff <= clamp_c(tpg_pkg::START_RESET);
         cur_y_ff <= clamp_c(tpg_pkg::START_RESET);
         head_ff  <= tpg_pkg::HEAD_DOWN;
         pen_ff   <= 1'b0;
         left_ff  <= '0;
         pend_ff  <= 1'b0;
         pi_ff    <= '0;
         po_ff    <= '0;
         infl_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         head_ff  <= head_in;
         pen_ff   <= pen_in;
         left_ff  <= left_in;
         pend_ff  <= pend_in;
         pi_ff    <= pi_in;
         po_ff    <= po_in;
         infl_ff  <= infl_in;
      end
   end

   // command word and walk payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff   <= req_tdata[2:0];
         steps_ff <= req_tdata[8:3];
      end
      mask_ff <= mask_in;
      row_ff  <= row_in;
      wrow_ff <= wrow_in;
   end

   tpg_grid_mem #(
      .GRID (GRID)
   ) u_grid_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   tpg_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (push_data),
      .take      (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (out_data),
      .stat      (fifo_stat)
   );

   assign rsp_tdata = {tpg_pkg::RSP_PAD_W'(0), out_data.pen_is_down, out_data.heading,
                       out_data.pos_y, out_data.pos_x, out_data.row_bits,
                       out_data.row_index};
   assign rsp_tuser = out_data.kind;
   assign rsp_tlast = out_data.last;

   // the queue never overflows
   `TPG_ASSERT_IMPLY(push_has_room, clock, reset, fifo_push, fifo_stat.can_push)
   // a walk never writes the row it reads in the same cycle
   `TPG_ASSERT_IMPLY(walk_rows_differ, clock, reset, mem_ctl.rd_en && mem_ctl.wr_en,
      mem_ctl.rd_row != mem_ctl.wr_row)
   // the last grid row ends the print
   `TPG_ASSERT_NEXT(print_ends_idle, clock, reset,
      fifo_push && (push_data.kind == tpg_pkg::KIND_ROW) && push_data.last,
      state_ff == S_IDLE)
   // the pen stays on the grid
   `TPG_ASSERT_IMPLY(pen_on_grid, clock, reset, 1'b1,
      (cur_x_ff <= MAX_C) && (cur_y_ff <= MAX_C))

endmodule
`default_nettype wire

### tb/turtle_plotter_grid_unit_tb.sv
// self-checking testbench of the turtle plotter grid unit: directed table then random commands
// keeps its own model of grid, pen and heading; needs tpg_pkg and the turtle_plotter_grid_unit rtl
module turtle_plotter_grid_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_CELLS     = tpg_pkg::GRID_DEF;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 80;
   localparam int RANDOM_PHASES  = 5;
   localparam int PHASE_ITEMS    = 37;
   localparam int DIRECTED_ROWS  = 23;

   // command codes the block treats as no-ops
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   // tdata: command [2:0], steps [8:3], zero [15:9]
   logic [tpg_pkg::REQ_TDATA_W-1:0]      req_tdata  = '0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   // tdata: row_index, row_bits, pos_x, pos_y, heading, pen_is_down, zero pad
   logic [tpg_pkg::RSP_TDATA_W-1:0]      rsp_tdata;
   // tuser: kind
   logic                                 rsp_tuser;
   logic                                 rsp_tlast;
   logic                                 csr_we     = 1'b0;
   logic [tpg_pkg::CSR_IDX_W-1:0]        csr_index  = '0;
   logic [tpg_pkg::COORD_W-1:0]          csr_wdata  = '0;

   turtle_plotter_grid_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- plotter model
   // private copy of the grid and pen state, advanced on every accepted command
   logic [tpg_pkg::ROW_W-1:0]   canvas [GRID_CELLS];
   logic [tpg_pkg::COORD_W-1:0] pen_col;
   logic [tpg_pkg::COORD_W-1:0] pen_row;
   logic [1:0]                  facing;
   logic                        pen_on;

   // words the block still owes us, oldest first
   tpg_pkg::rsp_type   owed_words [$];

   int                 mismatches = 0;
   logic               steady     = 1'b0;   // no idling on either side
   int                 holds_asked = 0;
   int                 holds_done  = 0;

   // pen position stops at the grid edges
   function automatic logic [tpg_pkg::COORD_W-1:0] edge_clamp(input int v);
      if (v < 0) return '0;
      if (v > GRID_CELLS - 1) return tpg_pkg::COORD_W'(GRID_CELLS - 1);
      return tpg_pkg::COORD_W'(v);
   endfunction

   // apply one command to the model and queue the words it produces
   task automatic trace_command(input logic [2:0] cmd, input logic [5:0] steps);
      tpg_pkg::rsp_type w;
      int      dx;
      int      dy;
      int      cx;
      int      cy;
      int      n;
      int      i;
      dx = 0;
      dy = 0;
      n  = steps;
      if (cmd == tpg_pkg::CMD_PRINT) begin
         // one row word per grid row, last mark on the bottom row
         for (i = 0; i < GRID_CELLS; i++) begin
            w             = '0;
            w.kind        = tpg_pkg::KIND_ROW;
            w.row_index   = tpg_pkg::COORD_W'(i);
            w.row_bits    = canvas[i];
            w.pos_x       = pen_col;
            w.pos_y       = pen_row;
            w.heading     = facing;
            w.pen_is_down = pen_on;
            w.last        = (i == GRID_CELLS - 1);
            owed_words.push_back(w);
         end
      end else begin
         case (cmd)
            tpg_pkg::CMD_PEN_UP: pen_on = 1'b0;
            tpg_pkg::CMD_PEN_DOWN: begin
               pen_on = 1'b1;
               canvas[pen_row][pen_col] = 1'b1;
            end
            tpg_pkg::CMD_TURN_R: facing = facing + tpg_pkg::TURN_R_INC;
            tpg_pkg::CMD_TURN_L: facing = facing + tpg_pkg::TURN_L_INC;
            tpg_pkg::CMD_MOVE: begin
               case (facing)
                  tpg_pkg::HEAD_DOWN:  dy = 1;
                  tpg_pkg::HEAD_RIGHT: dx = 1;
                  tpg_pkg::HEAD_UP:    dy = -1;
                  default:             dx = -1;
               endcase
               cx = pen_col;
               cy = pen_row;
               // marks run from the current cell; cells past an edge are dropped
               if (pen_on) begin
                  for (i = 0; i < n; i++) begin
                     if (cx + dx * i >= 0 && cx + dx * i < GRID_CELLS &&
                         cy + dy * i >= 0 && cy + dy * i < GRID_CELLS)
                        canvas[cy + dy * i][cx + dx * i] = 1'b1;
                  end
               end
               pen_col = edge_clamp(cx + dx * n);
               pen_row = edge_clamp(cy + dy * n);
            end
            default: ;   // spare codes change nothing
         endcase
         w             = '0;
         w.kind        = tpg_pkg::KIND_STATUS;
         w.pos_x       = pen_col;
         w.pos_y       = pen_row;
         w.heading     = facing;
         w.pen_is_down = pen_on;
         w.last        = 1'b1;
         owed_words.push_back(w);
      end
   endtask

   // ---------------------------------------------------------------- command side
   // offer one command word and hold it until taken; valid stays high afterwards
   task automatic send_command(input logic [2:0] cmd, input logic [5:0] steps);
      if (!steady && $urandom_range(0, 99) < 33) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, steps, cmd};
      do @(posedge clock); while (!req_tready);
      trace_command(cmd, steps);
   endtask

   // let everything drain, then move the start registers and the pen with them
   task automatic place_pen(input logic [tpg_pkg::COORD_W-1:0] col,
                            input logic [tpg_pkg::COORD_W-1:0] row);
      req_tvalid <= 1'b0;
      while (owed_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= tpg_pkg::CSR_START_X;
      csr_wdata <= col;
      @(posedge clock);
      pen_col = edge_clamp(col);
      csr_index <= tpg_pkg::CSR_START_Y;
      csr_wdata <= row;
      @(posedge clock);
      pen_row = edge_clamp(row);
      csr_we <= 1'b0;
   endtask

   // random command, weighted toward pen-down drawing with mostly short moves
   task automatic send_random_command();
      int          pick;
      logic [2:0]  cmd;
      logic [5:0]  steps;
      pick = $urandom_range(0, 99);
      if (pick < 8)       cmd = tpg_pkg::CMD_PEN_UP;
      else if (pick < 22) cmd = tpg_pkg::CMD_PEN_DOWN;
      else if (pick < 34) cmd = tpg_pkg::CMD_TURN_R;
      else if (pick < 44) cmd = tpg_pkg::CMD_TURN_L;
      else if (pick < 88) cmd = tpg_pkg::CMD_MOVE;
      else if (pick < 94) cmd = tpg_pkg::CMD_PRINT;
      else if (pick < 97) cmd = CMD_SPARE_6;
      else                cmd = CMD_SPARE_7;
      if ($urandom_range(0, 99) < 70) steps = 6'($urandom_range(0, 12));
      else                            steps = 6'($urandom_range(0, 63));
      send_command(cmd, steps);
   endtask

   // ---------------------------------------------------------------- directed table
   // typed: status word fields given here instead of by the model
   typedef struct packed {
      logic [2:0]                  cmd;
      logic [5:0]                  steps;
      logic                        typed;
      logic [tpg_pkg::COORD_W-1:0] col;
      logic [tpg_pkg::COORD_W-1:0] row;
      logic [1:0]                  hd;
      logic                        pen;
   } plot_row_type;

   plot_row_type directed_rows [DIRECTED_ROWS];

   initial begin
      directed_rows = '{
         // state after reset
         '{tpg_pkg::CMD_PEN_UP,   6'd0,  1'b1, 6'd12, 6'd12, tpg_pkg::HEAD_DOWN,  1'b0},
         // blank grid
         '{tpg_pkg::CMD_PRINT,    6'd0,  1'b0, 6'd0,  6'd0,  tpg_pkg::HEAD_DOWN,  1'b0},
         // steps ignored
         '{tpg_pkg::CMD_PEN_DOWN, 6'd63, 1'b1, 6'd12, 6'd12, tpg_pkg::HEAD_DOWN,  1'b1},
         // zero steps
         '{tpg_pkg::CMD_MOVE,     6'd0,  1'b1, 6'd12, 6'd12, tpg_pkg::HEAD_DOWN,  1'b1},
         // runs off the bottom
         '{tpg_pkg::CMD_MOVE,     6'd63, 1'b1, 6'd12, 6'd63, tpg_pkg::HEAD_DOWN,  1'b1},
         '{tpg_pkg::CMD_TURN_R,   6'd21, 1'b1, 6'd12, 6'd63, tpg_pkg::HEAD_RIGHT, 1'b1},
         // off the right edge
         '{tpg_pkg::CMD_MOVE,     6'd63, 1'b1, 6'd63, 6'd63, tpg_pkg::HEAD_RIGHT, 1'b1},
         '{tpg_pkg::CMD_TURN_R,   6'd0,  1'b0, 6'd0,  6'd0,  tpg_pkg::HEAD_DOWN,  1'b0},
         // short move up
         '{tpg_pkg::CMD_MOVE,     6'd5,  1'b0, 6'd0,  6'd0,  tpg_pkg::HEAD_DOWN,  1'b0},
         '{tpg_pkg::CMD_TURN_R,   6'd0,  1'b0, 6'd0,  6'd0,  tpg_pkg::HEAD_DOWN,  1'b0},
         // off the left edge
         '{tpg_pkg::CMD_MOVE,     6'd63, 1'b1, 6'd0,  6'd58, tpg_pkg::HEAD_LEFT,  1'b1},
         '{tpg_pkg::CMD_TURN_L,   6'd0,  1'b0, 6'd0,  6'd0,  tpg_pkg::HEAD_DOWN,  1'b0},
         '{tpg_pkg::CMD_TURN_L,   6'd42, 1'b0, 6'd0,  6'd0,  tpg_pkg::HEAD_DOWN,  1'b0},
         '{tpg_pkg::CMD_TURN_L,   6'd0,  1'b0, 6'd0,  6'd0,  tpg_pkg::HEAD_DOWN,  1'b0},
         // heading wraps
         '{tpg_pkg::CMD_TURN_L,   6'd0,  1'b1, 6'd0,  6'd58, tpg_pkg::HEAD_LEFT,  1'b1},
         '{tpg_pkg::CMD_PEN_UP,   6'd0,  1'b1, 6'd0,  6'd58, tpg_pkg::HEAD_LEFT,  1'b0},
         // pinned at the edge
         '{tpg_pkg::CMD_MOVE,     6'd10, 1'b1, 6'd0,  6'd58, tpg_pkg::HEAD_LEFT,  1'b0},
         '{tpg_pkg::CMD_TURN_L,   6'd0,  1'b0, 6'd0,  6'd0,  tpg_pkg::HEAD_DOWN,  1'b0},
         // pen-up move still moves
         '{tpg_pkg::CMD_MOVE,     6'd63, 1'b1, 6'd0,  6'd0,  tpg_pkg::HEAD_UP,    1'b0},
         '{CMD_SPARE_6,           6'd0,  1'b1, 6'd0,  6'd0,  tpg_pkg::HEAD_UP,    1'b0},
         '{CMD_SPARE_7,           6'd63, 1'b1, 6'd0,  6'd0,  tpg_pkg::HEAD_UP,    1'b0},
         // corner cell
         '{tpg_pkg::CMD_PEN_DOWN, 6'd0,  1'b1, 6'd0,  6'd0,  tpg_pkg::HEAD_UP,    1'b1},
         '{tpg_pkg::CMD_PRINT,    6'd0,  1'b0, 6'd0,  6'd0,  tpg_pkg::HEAD_DOWN,  1'b0}
      };
   end

   // ---------------------------------------------------------------- main sequence
   initial begin
      tpg_pkg::rsp_type w;
      int      k;
      int      p;
      for (k = 0; k < GRID_CELLS; k++) canvas[k] = '0;
      pen_col = tpg_pkg::START_RESET;
      pen_row = tpg_pkg::START_RESET;
      facing  = tpg_pkg::HEAD_DOWN;
      pen_on  = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part on the reset start position
      for (k = 0; k < DIRECTED_ROWS; k++) begin
         send_command(directed_rows[k].cmd, directed_rows[k].steps);
         if (directed_rows[k].typed) begin
            w             = owed_words.pop_back();
            w.pos_x       = directed_rows[k].col;
            w.pos_y       = directed_rows[k].row;
            w.heading     = directed_rows[k].hd;
            w.pen_is_down = directed_rows[k].pen;
            owed_words.push_back(w);
         end
      end

      // random phases, each from its own start position
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       place_pen('0, '0);
            1:       place_pen('1, '1);
            3:       place_pen('1, '0);
            default: place_pen(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
         endcase
         steady = (p == 2);
         // receiver goes quiet for a long stretch while commands keep coming
         if (p == 3) holds_asked++;
         for (k = 0; k < PHASE_ITEMS; k++) send_random_command();
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      while (owed_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0 && owed_words.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // ---------------------------------------------------------------- result side
   // ready toggles at random, or stays low during a requested hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (holds_done != holds_asked) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 33);
         end
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
         mismatches++;
      end
   endtask

   // every accepted result word against the oldest owed word
   always @(posedge clock) begin
      tpg_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual kind %b tdata %h last %b",
                     $realtime, rsp_tuser, rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            want = owed_words.pop_front();
            check_field("kind",        64'(want.kind),        64'(rsp_tuser));
            check_field("row_index",   64'(want.row_index),   64'(rsp_tdata[5:0]));
            check_field("row_bits",    want.row_bits,         rsp_tdata[69:6]);
            check_field("pos_x",       64'(want.pos_x),       64'(rsp_tdata[75:70]));
            check_field("pos_y",       64'(want.pos_y),       64'(rsp_tdata[81:76]));
            check_field("heading",     64'(want.heading),     64'(rsp_tdata[83:82]));
            check_field("pen_is_down", 64'(want.pen_is_down), 64'(rsp_tdata[84]));
            check_field("last",        64'(want.last),        64'(rsp_tlast));
         end
      end
   end

   // watchdog: too long without any word moving on either side
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
